// ===== src/as2f_pkg.sv =====
// Package for the audio sample to float32 converter.
// Holds the word types, format codes and shared constants; no dependencies.
package as2f_pkg;

    typedef struct packed {
        logic [63:0] raw_sample;
        logic        frame_last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        converted;
        logic        frame_last_out;
    } t_out_word;

    localparam logic [2:0] FMT_INT16   = 3'd0;
    localparam logic [2:0] FMT_INT24   = 3'd1;
    localparam logic [2:0] FMT_INT32   = 3'd2;
    localparam logic [2:0] FMT_FLOAT32 = 3'd3;
    localparam logic [2:0] FMT_FLOAT64 = 3'd4;

    localparam logic [31:0] F32_INF  = 32'h7F80_0000;
    localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;

endpackage

// ===== src/audio_sample_to_float32_top.sv =====
// Top level of the audio sample to float32 converter.
// Depends on as2f_pkg for the word types and format codes.
//
// Usage:
//   Set the format register through i_cfg_we / i_cfg_data while idle
//   (0 int16, 1 int24, 2 int32, 3 float32, 4 float64, others unsupported).
//   A sample word is taken at each rising edge where start is high and busy
//   is low; busy is always low, so one word may be taken every cycle.
//   The sample is captured in an input register, converted by combinational
//   logic (leading-one search, round to nearest even) and captured in the
//   result register at the next edge. The converted word is then strobed on
//   o_result for one cycle. o_result_valid is high for exactly one cycle per
//   word.
//   Throughput is one word per cycle, set by the single conversion stage.
//   The receiver cannot stall; each result must be taken when strobed.
//   Reset clears the pipeline valid flags and sets the format to int16.
module audio_sample_to_float32_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  as2f_pkg::t_in_word  i_sample,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_data,
    output logic                o_result_valid,
    output as2f_pkg::t_out_word o_result
);
    import as2f_pkg::*;

    logic [2:0] r_fmt;
    logic       r_in_vld;
    t_in_word   r_in;
    logic       r_out_vld;
    t_out_word  r_out;
    t_out_word  n_out;

    assign busy = 1'b0;

    // Format register and input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_INT16;
            r_in_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_fmt <= i_cfg_data;
            r_in_vld <= start;
        end
        if (start) r_in <= i_sample;
    end

    // Integer path: sign-extend to 32 bits and take the magnitude.
    logic [31:0] int_v;
    logic [31:0] int_mag;
    logic [7:0]  int_frac;
    logic [4:0]  lead;
    logic [31:0] norm;
    logic [24:0] int_rnd;
    logic        int_grd;
    logic        int_stk;
    logic [7:0]  int_exp;
    logic [31:0] int_bits;

    always_comb begin
        case (r_fmt)
            FMT_INT16: begin
                int_v    = {{16{r_in.raw_sample[15]}}, r_in.raw_sample[15:0]};
                int_frac = 8'd15;
            end
            FMT_INT24: begin
                int_v    = {{8{r_in.raw_sample[23]}}, r_in.raw_sample[23:0]};
                int_frac = 8'd23;
            end
            default: begin
                int_v    = r_in.raw_sample[31:0];
                int_frac = 8'd31;
            end
        endcase
        int_mag = int_v[31] ? (32'd0 - int_v) : int_v;
        lead = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (int_mag[i]) lead = 5'(i);
        end
        // Normalise so the leading one sits at bit 31.
        norm    = int_mag << (5'd31 - lead);
        int_grd = norm[7];
        int_stk = |norm[6:0];
        int_rnd = {1'b0, norm[31:8]}
                  + 25'(int_grd && (int_stk || norm[8]));
        int_exp = 8'(lead) + 8'd127 - int_frac + 8'(int_rnd[24]);
        if (int_mag == 32'd0)
            int_bits = 32'd0;
        else if (int_rnd[24])
            int_bits = {int_v[31], int_exp, int_rnd[23:1]};
        else
            int_bits = {int_v[31], int_exp, int_rnd[22:0]};
    end

    // float64 narrowing.
    logic        d_sign;
    logic [10:0] d_ex;
    logic [51:0] d_frac;
    logic [31:0] nrm_bits;
    logic [28:0] nrm_rem;
    logic [52:0] mant53;
    logic [6:0]  sh;
    logic [52:0] sub_q;
    logic [52:0] sub_rem;
    logic [52:0] sub_half;
    logic [31:0] sub_bits;
    logic [31:0] dbl_bits;

    always_comb begin
        d_sign   = r_in.raw_sample[63];
        d_ex     = r_in.raw_sample[62:52];
        d_frac   = r_in.raw_sample[51:0];
        nrm_bits = {1'b0, 8'(d_ex - 11'd896), d_frac[51:29]};
        nrm_rem  = d_frac[28:0];
        if (nrm_rem > 29'h1000_0000 || (nrm_rem == 29'h1000_0000 && nrm_bits[0]))
            nrm_bits = nrm_bits + 32'd1;
        mant53   = {1'b1, d_frac};
        sh       = 7'(11'd926 - d_ex);
        sub_q    = mant53 >> sh;
        sub_rem  = mant53 & ((53'd1 << sh) - 53'd1);
        sub_half = 53'd1 << (sh - 7'd1);
        sub_bits = sub_q[31:0];
        if (sub_rem > sub_half || (sub_rem == sub_half && sub_bits[0]))
            sub_bits = sub_bits + 32'd1;
        if (d_ex == 11'h7FF) begin
            if (d_frac != 52'd0)
                dbl_bits = {d_sign, 31'd0} | F32_QNAN | {10'd0, d_frac[50:29]};
            else
                dbl_bits = {d_sign, F32_INF[30:0]};
        end else if (d_ex >= 11'd1151)
            dbl_bits = {d_sign, F32_INF[30:0]};
        else if (d_ex >= 11'd897)
            dbl_bits = {d_sign, 31'd0} | nrm_bits;
        else if (d_ex < 11'd873)
            dbl_bits = {d_sign, 31'd0};
        else
            dbl_bits = {d_sign, 31'd0} | sub_bits;
    end

    // Format selection into the result word.
    always_comb begin
        n_out.frame_last_out = r_in.frame_last;
        n_out.converted      = 1'b1;
        unique case (r_fmt) inside
            FMT_INT16, FMT_INT24, FMT_INT32: n_out.float_bits = int_bits;
            FMT_FLOAT32: n_out.float_bits = r_in.raw_sample[31:0];
            FMT_FLOAT64: n_out.float_bits = dbl_bits;
            default: begin
                n_out.float_bits = 32'd0;
                n_out.converted  = 1'b0;
            end
        endcase
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else          r_out_vld <= r_in_vld;
        if (r_in_vld) r_out <= n_out;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

endmodule

// ===== sim/tb_audio_sample_to_float32_top.sv =====
// Self-checking testbench for the audio sample to float32 converter.
// Depends on as2f_pkg and audio_sample_to_float32_top; predicts each result
// word in-bench and compares it field by field with what the block returns.
module tb_audio_sample_to_float32_top;
    import as2f_pkg::*;

    // Format codes beyond the package's supported set.
    localparam logic [2:0] FMT_RSVD5 = 3'd5;
    localparam logic [2:0] FMT_RSVD6 = 3'd6;
    localparam logic [2:0] FMT_RSVD7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_CYCLES  = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_word    i_sample = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_data = '0;
    logic        o_result_valid;
    t_out_word   o_result;

    logic [2:0]  fmt_shadow = FMT_INT16;
    t_out_word   pending_words[$];
    int unsigned gap_pct = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    audio_sample_to_float32_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Two's complement value scaled by 2^-frac, rounded to nearest even.
    function automatic logic [31:0] fixed_to_f32(logic [31:0] v, int unsigned frac);
        logic        sgn;
        logic [31:0] mag;
        logic [31:0] mant;
        logic [31:0] rem;
        logic [31:0] half;
        int unsigned p;
        int unsigned k;
        logic [31:0] biased;
        sgn = v[31];
        mag = sgn ? (32'd0 - v) : v;
        if (mag == 32'd0)
            return 32'd0;
        p = 31;
        while (mag[p] == 1'b0)
            p--;
        if (p > 23) begin
            k = p - 23;
            rem = mag & ((32'd1 << k) - 32'd1);
            half = 32'd1 << (k - 1);
            mant = mag >> k;
            if (rem > half || (rem == half && mant[0]))
                mant++;
            if (mant == (32'd1 << 24)) begin
                mant = mant >> 1;
                p++;
            end
        end else begin
            mant = mag << (23 - p);
        end
        biased = p + 127 - frac;
        return {sgn, biased[7:0], mant[22:0]};
    endfunction

    // binary64 narrowed to binary32, round to nearest even.
    function automatic logic [31:0] double_to_f32(logic [63:0] d);
        logic [31:0] sgn;
        int unsigned ex;
        logic [63:0] frac;
        logic [63:0] mant53;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] bits;
        int unsigned shift;
        sgn = {d[63], 31'd0};
        ex = {21'd0, d[62:52]};
        frac = {12'd0, d[51:0]};
        if (ex == 2047) begin
            if (frac != 0)
                return sgn | F32_QNAN | {10'd0, frac[50:29]};
            return sgn | F32_INF;
        end
        if (ex >= 1151)
            return sgn | F32_INF;
        if (ex >= 897) begin
            bits = ((ex - 896) << 23) | {9'd0, frac[51:29]};
            rem = frac & 64'h1FFF_FFFF;
            half = 64'h1000_0000;
            if (rem > half || (rem == half && bits[0]))
                bits++;
            return sgn | bits;
        end
        if (ex == 0)
            return sgn;
        shift = 926 - ex;
        if (shift >= 54)
            return sgn;
        mant53 = (64'd1 << 52) | frac;
        bits = 32'(mant53 >> shift);
        rem = mant53 & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && bits[0]))
            bits++;
        return sgn | bits;
    endfunction

    function automatic t_out_word convert_word(t_in_word w, logic [2:0] fmt);
        t_out_word r;
        r.float_bits = '0;
        r.converted = 1'b1;
        r.frame_last_out = w.frame_last;
        case (fmt)
            FMT_INT16: r.float_bits =
                fixed_to_f32({{16{w.raw_sample[15]}}, w.raw_sample[15:0]}, 15);
            FMT_INT24: r.float_bits =
                fixed_to_f32({{8{w.raw_sample[23]}}, w.raw_sample[23:0]}, 23);
            FMT_INT32: r.float_bits = fixed_to_f32(w.raw_sample[31:0], 31);
            FMT_FLOAT32: r.float_bits = w.raw_sample[31:0];
            FMT_FLOAT64: r.float_bits = double_to_f32(w.raw_sample);
            default: r.converted = 1'b0;
        endcase
        return r;
    endfunction

    // Predict a result for every word the block takes.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            pending_words = {pending_words, convert_word(i_sample, fmt_shadow)};
    end

    // Compare each strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_result_valid) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word %h", o_result);
                fail_count++;
            end else begin
                exp_word = pending_words.pop_front();
                if (o_result.float_bits !== exp_word.float_bits) begin
                    $error("float_bits: expected %h, got %h",
                           exp_word.float_bits, o_result.float_bits);
                    fail_count++;
                end
                if (o_result.converted !== exp_word.converted) begin
                    $error("converted: expected %b, got %b",
                           exp_word.converted, o_result.converted);
                    fail_count++;
                end
                if (o_result.frame_last_out !== exp_word.frame_last_out) begin
                    $error("frame_last_out: expected %b, got %b",
                           exp_word.frame_last_out, o_result.frame_last_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Send one word, then idle cycle by cycle with probability gap_pct percent.
    task automatic send_word(logic [63:0] raw, logic last);
        start <= 1'b1;
        i_sample <= '{raw_sample: raw, frame_last: last};
        do @(posedge i_clk); while (busy);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Wait for the block to drain, then write the format register.
    task automatic set_format(logic [2:0] fmt);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= fmt;
        @(posedge i_clk);
        fmt_shadow = fmt;
        i_cfg_we <= 1'b0;
    endtask

    // Extremes, rounding ties, the float64 special values and a reserved format code.
    task automatic test_directed();
        send_word(64'h0, 1'b0);
        send_word(64'h7FFF, 1'b1);
        send_word(64'h8000, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        set_format(FMT_INT24);
        send_word(64'h7F_FFFF, 1'b0);
        send_word(64'hFFFF_FFFF_FF80_0000, 1'b0);
        send_word(64'h1, 1'b1);
        set_format(FMT_INT32);
        send_word(64'h8000_0000, 1'b0);
        send_word(64'hFFFF_FFFF_7FFF_FFFF, 1'b0);
        send_word(64'h0100_0001, 1'b1);
        send_word(64'h0100_0003, 1'b0);
        set_format(FMT_FLOAT32);
        send_word(64'h1234_5678_DEAD_BEEF, 1'b1);
        set_format(FMT_FLOAT64);
        send_word(64'h7FF0_0000_0000_0000, 1'b0);
        send_word(64'hFFF0_0000_0000_0001, 1'b0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h47EF_FFFF_F000_0000, 1'b0);
        send_word(64'h3FF0_0000_1000_0000, 1'b0);
        send_word(64'h36A0_0000_0000_0000, 1'b1);
        send_word(64'h0000_0000_0000_0001, 1'b0);
        set_format(FMT_RSVD5);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'h0, 1'b0);
    endtask

    // Random raw bits with a bias towards rounding ties and range edges.
    function automatic logic [63:0] pick_raw(logic [2:0] fmt);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(3))
            0: raw[28:0] = 29'h1000_0000;
            1: raw[7:0] = 8'h80;
            default: ;
        endcase
        if (fmt == FMT_FLOAT64 && $urandom_range(1))
            raw[62:52] = (11'($urandom_range(860, 1160)));
        if (fmt == FMT_FLOAT64 && $urandom_range(9) == 0)
            raw[62:52] = $urandom_range(1) ? 11'h7FF : 11'h0;
        if (fmt == FMT_INT32 && $urandom_range(3) == 0)
            raw[31:0] = raw[31:0] >> $urandom_range(31);
        return raw;
    endfunction

    task automatic test_random(logic [2:0] fmt, int unsigned count);
        set_format(fmt);
        repeat (count)
            send_word(pick_raw(fmt), 1'(($urandom_range(7) == 0)));
    endtask

    // Run every format under one idling pattern.
    task automatic test_all_formats(int unsigned pct, int unsigned per_fmt);
        gap_pct = pct;
        test_random(FMT_FLOAT64, per_fmt * 2);
        test_random(FMT_INT32, per_fmt * 2);
        test_random(FMT_INT16, per_fmt);
        test_random(FMT_INT24, per_fmt);
        test_random(FMT_FLOAT32, per_fmt / 2);
        test_random(FMT_RSVD6, 10);
        test_random(FMT_RSVD7, 10);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_pct = 18;
        test_directed();
        test_all_formats(18, 45);
        test_all_formats(58, 45);
        test_all_formats(0, 45);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
src/as2f_pkg.sv
src/audio_sample_to_float32_top.sv
sim/tb_audio_sample_to_float32_top.sv
